// ===== sv/rta16_pkg.sv =====
// Shared types and constants of the RGB to ANSI 16-color classifier.
package rta16_pkg;

  // Channel that holds the maximum, after the blue-over-green-over-red tie rule.
  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  // Features of one pixel taken from the first pipeline stage.
  typedef struct packed {
    logic [7:0]        spread;  // max minus min
    logic [9:0]        sum;     // red + green + blue
    chan_t             chan;    // channel that selects the hue formula
    logic signed [8:0] diff;    // numerator difference of the hue formula
  } feat_t;

  // Register indexes of the configuration port.
  localparam logic CFG_BW_THRESH   = 1'b0;
  localparam logic CFG_GRAY_THRESH = 1'b1;

  localparam logic [6:0] BW_THRESH_RESET   = 7'd32;
  localparam logic [5:0] GRAY_THRESH_RESET = 6'd8;

  // Sum that splits dark from bright pixels, and the full-scale sum.
  localparam logic [9:0] SUM_MID = 10'd384;
  localparam logic [9:0] SUM_MAX = 10'd765;

  // ANSI palette indexes.
  localparam logic [3:0] COLOR_BLACK          = 4'd0;
  localparam logic [3:0] COLOR_RED            = 4'd1;
  localparam logic [3:0] COLOR_GREEN          = 4'd2;
  localparam logic [3:0] COLOR_YELLOW         = 4'd3;
  localparam logic [3:0] COLOR_BLUE           = 4'd4;
  localparam logic [3:0] COLOR_MAGENTA        = 4'd5;
  localparam logic [3:0] COLOR_CYAN           = 4'd6;
  localparam logic [3:0] COLOR_LIGHT_GRAY     = 4'd7;
  localparam logic [3:0] COLOR_DARK_GRAY      = 4'd8;
  localparam logic [3:0] COLOR_BRIGHT_RED     = 4'd9;
  localparam logic [3:0] COLOR_BRIGHT_GREEN   = 4'd10;
  localparam logic [3:0] COLOR_BRIGHT_YELLOW  = 4'd11;
  localparam logic [3:0] COLOR_BRIGHT_BLUE    = 4'd12;
  localparam logic [3:0] COLOR_BRIGHT_MAGENTA = 4'd13;
  localparam logic [3:0] COLOR_BRIGHT_CYAN    = 4'd14;
  localparam logic [3:0] COLOR_WHITE          = 4'd15;

endpackage

// ===== sv/rta16_feature.sv =====
// Pixel feature extraction: sum, spread, max channel and hue numerator.
module rta16_feature
  import rta16_pkg::*;
(
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output feat_t      feat
);

  logic [7:0] hi;
  logic [7:0] lo;

  always_comb begin
    hi = (red > green) ? red : green;
    hi = (hi > blue) ? hi : blue;
    lo = (red < green) ? red : green;
    lo = (lo < blue) ? lo : blue;

    feat.spread = hi - lo;
    feat.sum    = {2'b00, red} + {2'b00, green} + {2'b00, blue};

    // Blue wins ties over green, green over red.
    if (blue == hi) begin
      feat.chan = CH_BLUE;
      feat.diff = $signed({1'b0, red}) - $signed({1'b0, green});
    end else if (green == hi) begin
      feat.chan = CH_GREEN;
      feat.diff = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      feat.chan = CH_RED;
      feat.diff = $signed({1'b0, green}) - $signed({1'b0, blue});
    end
  end

endmodule

// ===== sv/rgb_to_ansi16_classifier.sv =====
// Top level: three-stage pipelined RGB to ANSI 16-color classifier.
// Throughput is one pixel per cycle while the output side is ready; each stage has its own valid bit and
// loads whenever the stage after it is empty or moving, so bubbles close up.
// Reset (synchronous, active high) empties the pipeline and sets the black/white
// threshold to 32 and the gray threshold to 8.
module rgb_to_ansi16_classifier
  import rta16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] color_index, [7:4] zero

  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata
);

  // Configuration registers. The user must change them only while the pipeline is idle; the block does not enforce it.
  logic [6:0] bw_thresh;
  logic [5:0] gray_thresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      bw_thresh   <= BW_THRESH_RESET;
      gray_thresh <= GRAY_THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BW_THRESH:   bw_thresh   <= cfg_wdata;
        CFG_GRAY_THRESH: gray_thresh <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Stage advance. Each stage takes a new beat when it is empty or when the
  // stage after it is taking its current beat.
  logic valid1;
  logic valid2;
  logic out_valid;
  logic load_out;
  logic load2;
  logic load1;

  assign load_out      = ~out_valid | m_axis_tready;
  assign load2         = ~valid2 | load_out;
  assign load1         = ~valid1 | load2;
  assign s_axis_tready = load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load1)    valid1    <= s_axis_tvalid;
      if (load2)    valid2    <= valid1;
      if (load_out) out_valid <= valid2;
    end
  end

  // Stage 1: sum, spread, max channel and the signed hue numerator.
  feat_t feat_in;
  feat_t feat1;

  rta16_feature u_feature (
    .red   (s_axis_tdata[7:0]),
    .green (s_axis_tdata[15:8]),
    .blue  (s_axis_tdata[23:16]),
    .feat  (feat_in)
  );

  always_ff @(posedge clk) begin
    if (load1) feat1 <= feat_in;
  end

  // Stage 2: the products that replace the divisions.
  // The hue quotient p = trunc(600*|diff|/spread) is only ever compared with
  // 300, so p >= 300 becomes 600*|diff| >= 300*spread and p > 300 becomes
  // 600*|diff| >= 301*spread. Saturation s <= gray becomes
  // 60*spread < (gray+1)*den, where den is the sum for dark pixels and
  // 765 minus the sum for bright ones.
  logic        neg_c;
  logic [7:0]  mag_c;
  logic        dark_c;
  logic [8:0]  den_c;
  logic [8:0]  bw3_c;
  logic [9:0]  white_lim_c;
  logic [7:0]  bw_comp_c;

  logic [17:0] mag600;
  logic [16:0] spr300;
  logic [16:0] spr301;
  logic [13:0] spr60;
  logic [15:0] sat_lim;
  logic        neg2;
  chan_t       chan2;
  logic        dark2;
  logic        black2;
  logic        white2;
  logic        flat2;

  always_comb begin
    neg_c       = feat1.diff[8];
    mag_c       = neg_c ? 8'(-feat1.diff) : feat1.diff[7:0];
    dark_c      = feat1.sum < SUM_MID;
    den_c       = dark_c ? feat1.sum[8:0] : 9'(SUM_MAX - feat1.sum);
    bw3_c       = 9'({2'b00, bw_thresh}) * 9'd3;
    bw_comp_c   = 8'd255 - {1'b0, bw_thresh};
    white_lim_c = 10'({2'b00, bw_comp_c}) * 10'd3;
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      mag600  <= 18'(mag_c) * 18'd600;
      spr300  <= 17'(feat1.spread) * 17'd300;
      spr301  <= 17'(feat1.spread) * 17'd301;
      spr60   <= 14'(feat1.spread) * 14'd60;
      sat_lim <= 16'({1'b0, gray_thresh} + 7'd1) * 16'(den_c);
      neg2    <= neg_c;
      chan2   <= feat1.chan;
      dark2   <= dark_c;
      black2  <= feat1.sum < {1'b0, bw3_c};
      white2  <= feat1.sum > white_lim_c;
      flat2   <= feat1.spread == 8'd0;
    end
  end

  // Stage 3: compares and the palette choice.
  // The thresholds of the hue sectors reduce, per formula, to "the quotient
  // is past 300 on the negative or positive side". Dark pixels use the
  // strict test and bright ones the inclusive one, matching where the
  // sector boundaries belong to each palette half.
  logic       p_ge;
  logic       p_gt;
  logic       gray_c;
  logic       past_c;
  logic [3:0] color_c;
  logic [3:0] color_index;

  always_comb begin
    p_ge   = mag600 >= 18'(spr300);
    p_gt   = mag600 >= 18'(spr301);
    gray_c = flat2 | (16'(spr60) < sat_lim);
    past_c = dark2 ? p_gt : p_ge;

    if (black2) begin
      color_c = COLOR_BLACK;
    end else if (white2) begin
      color_c = COLOR_WHITE;
    end else if (gray_c) begin
      color_c = dark2 ? COLOR_DARK_GRAY : COLOR_LIGHT_GRAY;
    end else if (dark2) begin
      case (chan2)
        CH_BLUE:  color_c = past_c ? (neg2 ? COLOR_CYAN : COLOR_MAGENTA) : COLOR_BLUE;
        CH_GREEN: color_c = past_c ? (neg2 ? COLOR_YELLOW : COLOR_CYAN) : COLOR_GREEN;
        default:  color_c = past_c ? (neg2 ? COLOR_MAGENTA : COLOR_YELLOW) : COLOR_RED;
      endcase
    end else begin
      case (chan2)
        CH_BLUE:  color_c = past_c ? (neg2 ? COLOR_BRIGHT_CYAN : COLOR_BRIGHT_MAGENTA)
                                   : COLOR_BRIGHT_BLUE;
        CH_GREEN: color_c = past_c ? (neg2 ? COLOR_BRIGHT_YELLOW : COLOR_BRIGHT_CYAN)
                                   : COLOR_BRIGHT_GREEN;
        default:  color_c = past_c ? (neg2 ? COLOR_BRIGHT_MAGENTA : COLOR_BRIGHT_YELLOW)
                                   : COLOR_BRIGHT_RED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) color_index <= color_c;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, color_index};

endmodule

// ===== tb/sv/tb_rgb_to_ansi16_classifier.sv =====
// Self-checking testbench of the RGB to ANSI 16-color classifier.
module tb_rgb_to_ansi16_classifier
  import rta16_pkg::*;
();

  // The run is ended as a failure if it has not finished by this cycle.
  localparam int CYCLE_LIMIT    = 200000;
  // Cycles from an accepted input beat to its output beat.
  localparam int PIPE_LATENCY   = 3;
  // Random pixels sent under each register setting.
  localparam int PIXELS_PER_SET = 118;
  // Length of the long output hold-off that fills the pipeline.
  localparam int HOLD_OFF_LEN   = 80;
  localparam int DIRECTED_ROWS  = 30;
  localparam int FIXED_SETTINGS = 7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [7:0] red, [15:8] green, [23:16] blue
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [3:0] color_index, [7:4] zero
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_BW_THRESH;
  logic [6:0] cfg_wdata = '0;

  rgb_to_ansi16_classifier dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A directed row either sends a pixel whose color is typed in, sends a pixel
  // whose color comes from the predictor, or writes a register.
  typedef enum logic [1:0] {
    ROW_KNOWN,
    ROW_PREDICT,
    ROW_SETUP
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic       reg_index;
    logic [6:0] reg_value;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] color;
  } stim_row_t;

  typedef struct packed {
    logic [6:0] bw;
    logic [6:0] gray;
  } setting_t;

  // The directed part runs first under the reset thresholds (32 and 8).
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Channel extremes and the black and white thresholds on either side.
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0,   8'd0,   8'd0,   8'd0, COLOR_BLACK},
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0, 8'd255, 8'd255, 8'd255, COLOR_WHITE},
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0,  8'd31,  8'd31,  8'd31, COLOR_BLACK},
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0,  8'd32,  8'd32,  8'd32, COLOR_DARK_GRAY},
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0, 8'd223, 8'd223, 8'd223, COLOR_LIGHT_GRAY},
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0, 8'd224, 8'd224, 8'd224, COLOR_WHITE},
    // Grey on both sides of the dark/bright split at a sum of 384.
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0, 8'd127, 8'd128, 8'd128, COLOR_DARK_GRAY},
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0, 8'd128, 8'd128, 8'd128, COLOR_LIGHT_GRAY},
    // Primaries, then secondaries and ties between channels at the maximum.
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0, 8'd255,   8'd0,   8'd0, COLOR_RED},
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0,   8'd0, 8'd255,   8'd0, COLOR_GREEN},
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0,   8'd0,   8'd0, 8'd255, COLOR_BLUE},
    '{ROW_PREDICT, CFG_BW_THRESH,   7'd0, 8'd255, 8'd255,   8'd0, '0},
    '{ROW_PREDICT, CFG_BW_THRESH,   7'd0,   8'd0, 8'd255, 8'd255, '0},
    '{ROW_PREDICT, CFG_BW_THRESH,   7'd0, 8'd255,   8'd0, 8'd255, '0},
    '{ROW_PREDICT, CFG_BW_THRESH,   7'd0,   8'd0, 8'd200, 8'd200, '0},
    '{ROW_PREDICT, CFG_BW_THRESH,   7'd0, 8'd200, 8'd200,   8'd0, '0},
    // Red hue that goes negative and wraps, and hues right on a sector edge.
    '{ROW_PREDICT, CFG_BW_THRESH,   7'd0, 8'd255,   8'd0, 8'd100, '0},
    '{ROW_PREDICT, CFG_BW_THRESH,   7'd0, 8'd200, 8'd100,   8'd0, '0},
    '{ROW_PREDICT, CFG_BW_THRESH,   7'd0, 8'd255, 8'd155,  8'd55, '0},
    '{ROW_PREDICT, CFG_BW_THRESH,   7'd0, 8'd255, 8'd128, 8'd128, '0},
    // Both thresholds at zero: black and white vanish, a zero sum is grey.
    '{ROW_SETUP,   CFG_BW_THRESH,   7'd0,   8'd0,   8'd0,   8'd0, '0},
    '{ROW_SETUP,   CFG_GRAY_THRESH, 7'd0,   8'd0,   8'd0,   8'd0, '0},
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0,   8'd0,   8'd0,   8'd0, COLOR_DARK_GRAY},
    '{ROW_KNOWN,   CFG_BW_THRESH,   7'd0, 8'd255, 8'd255, 8'd255, COLOR_LIGHT_GRAY},
    '{ROW_PREDICT, CFG_BW_THRESH,   7'd0,   8'd1,   8'd0,   8'd0, '0},
    // A gray threshold above 60 makes every remaining pixel grey.
    '{ROW_SETUP,   CFG_GRAY_THRESH, 7'd63,  8'd0,   8'd0,   8'd0, '0},
    '{ROW_PREDICT, CFG_BW_THRESH,   7'd0, 8'd255,   8'd0,   8'd0, '0},
    // Widest black/white threshold; bit 6 of the gray write must be dropped.
    '{ROW_SETUP,   CFG_BW_THRESH,   7'd127, 8'd0,   8'd0,   8'd0, '0},
    '{ROW_SETUP,   CFG_GRAY_THRESH, 7'h48,  8'd0,   8'd0,   8'd0, '0},
    '{ROW_PREDICT, CFG_BW_THRESH,   7'd0, 8'd127, 8'd128, 8'd128, '0}
  };

  // Register settings of the random phases; one more random setting follows.
  setting_t fixed_settings [FIXED_SETTINGS] = '{
    '{7'd32,  7'd8},
    '{7'd0,   7'd0},
    '{7'd127, 7'd63},
    '{7'd0,   7'd60},
    '{7'd127, 7'd0},
    '{7'd5,   7'd61},
    '{7'd100, 7'd30}
  };

  // Shadow copy of the thresholds, kept in step with every register write.
  logic [6:0] bw_level   = BW_THRESH_RESET;
  logic [5:0] gray_level = GRAY_THRESH_RESET;

  logic [3:0] expected_colors [$];

  int cycle_count    = 0;
  int error_count    = 0;
  int pixels_checked = 0;
  int register_writes = 0;
  int input_stalls   = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int burst_left     = 0;
  logic [15:0] colors_seen = '0;

  function automatic logic [7:0] clamp8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Predicts the palette index of one pixel under the current thresholds.
  // Hue is in tenths of a degree; integer division truncates toward zero.
  function automatic logic [3:0] predict_color(input logic [7:0] r8, g8, b8);
    int r, g, b, top, bottom, spread, total, hue, sat;
    r = int'(r8);
    g = int'(g8);
    b = int'(b8);
    top = (r > g) ? r : g;
    top = (top > b) ? top : b;
    bottom = (r < g) ? r : g;
    bottom = (bottom < b) ? bottom : b;
    spread = top - bottom;
    total = r + g + b;
    hue = 0;
    sat = 0;
    // When several channels share the maximum, blue beats green beats red.
    if (spread > 0) begin
      if (b == top) hue = ((r - g) * 600) / spread + 2400;
      else if (g == top) hue = ((b - r) * 600) / spread + 1200;
      else begin
        hue = ((g - b) * 600) / spread;
        if (hue < 0) hue += 3600;
      end
    end
    if (total < int'(SUM_MID)) begin
      if (total > 0) sat = (60 * spread) / total;
    end else if (total < int'(SUM_MAX)) begin
      sat = (60 * spread) / (int'(SUM_MAX) - total);
    end
    if (total < int'(bw_level) * 3) return COLOR_BLACK;
    if (total > (255 - int'(bw_level)) * 3) return COLOR_WHITE;
    // Dark and bright sectors close their edges on opposite sides.
    if (total < int'(SUM_MID)) begin
      if (sat <= int'(gray_level)) return COLOR_DARK_GRAY;
      if (hue >= 3300 || hue <= 300) return COLOR_RED;
      if (hue < 900) return COLOR_YELLOW;
      if (hue <= 1500) return COLOR_GREEN;
      if (hue < 2100) return COLOR_CYAN;
      if (hue <= 2700) return COLOR_BLUE;
      return COLOR_MAGENTA;
    end
    if (sat <= int'(gray_level)) return COLOR_LIGHT_GRAY;
    if (hue > 3300 || hue < 300) return COLOR_BRIGHT_RED;
    if (hue <= 900) return COLOR_BRIGHT_YELLOW;
    if (hue < 1500) return COLOR_BRIGHT_GREEN;
    if (hue <= 2100) return COLOR_BRIGHT_CYAN;
    if (hue < 2700) return COLOR_BRIGHT_BLUE;
    return COLOR_BRIGHT_MAGENTA;
  endfunction

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Sends one pixel beat and records its expected color once it is accepted.
  // The sender works in bursts; between bursts tvalid may drop for a random gap.
  task automatic send_pixel(input logic [7:0] r, g, b, input logic [3:0] color);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do begin
      @(posedge clk);
      if (!s_axis_tready) input_stalls++;
    end while (!s_axis_tready);
    expected_colors.push_back(color);
  endtask

  // Registers change only with the pipeline empty: every pixel gives exactly
  // one beat, so an empty expectation queue means nothing is in flight.
  task automatic write_register(input logic idx, input logic [6:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BW_THRESH) bw_level = value;
    else gray_level = value[5:0];
    register_writes++;
    burst_left = 0;
  endtask

  // Random pixels: plain uniform ones plus shapes that land near the
  // interesting corners (grey, saturated, ties, sums near the thresholds).
  task automatic make_pixel(output logic [7:0] r, g, b);
    int base, target;
    logic [7:0] v, w;
    case ($urandom_range(0, 9))
      3: begin
        base = $urandom_range(0, 255);
        r = clamp8(base + $urandom_range(0, 6) - 3);
        g = clamp8(base + $urandom_range(0, 6) - 3);
        b = clamp8(base + $urandom_range(0, 6) - 3);
      end
      4: begin
        r = ($urandom_range(0, 2) == 0) ? 8'($urandom) : ($urandom_range(0, 1) ? 8'd255 : 8'd0);
        g = ($urandom_range(0, 2) == 0) ? 8'($urandom) : ($urandom_range(0, 1) ? 8'd255 : 8'd0);
        b = ($urandom_range(0, 2) == 0) ? 8'($urandom) : ($urandom_range(0, 1) ? 8'd255 : 8'd0);
      end
      5: begin
        v = 8'($urandom);
        w = 8'($urandom);
        case ($urandom_range(0, 2))
          0: begin r = v; g = v; b = w; end
          1: begin r = v; g = w; b = v; end
          default: begin r = w; g = v; b = v; end
        endcase
      end
      6: begin
        case ($urandom_range(0, 2))
          0: target = 3 * int'(bw_level);
          1: target = 3 * (255 - int'(bw_level));
          default: target = int'(SUM_MID);
        endcase
        base = target / 3 + $urandom_range(0, 2) - 1;
        r = clamp8(base + $urandom_range(0, 4) - 2);
        g = clamp8(base + $urandom_range(0, 4) - 2);
        b = clamp8(base + $urandom_range(0, 4) - 2);
      end
      default: begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end
    endcase
  endtask

  // Output side: checks every beat against the oldest expectation, then
  // picks tready for the next cycle. The stall pattern is redrawn from four
  // modes as the run goes on; a hold-off request keeps tready low for a long stretch.
  initial begin : result_checker
    int hold_left;
    int stall_mode;
    logic [3:0] want;
    hold_left = 0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch($sformatf("output beat 0x%0h with no pixel pending",
                                    m_axis_tdata));
        end else begin
          want = expected_colors.pop_front();
          if (m_axis_tdata[3:0] !== want)
            report_mismatch($sformatf("color_index %0d, expected %0d",
                                      m_axis_tdata[3:0], want));
          pixels_checked++;
          colors_seen[m_axis_tdata[3:0]] = 1'b1;
        end
      end
      if (cycle_count % 50 == 0) stall_mode = $urandom_range(0, 3);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_OFF_LEN;
      end
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (cycle_count % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    setting_t setting;
    logic [7:0] r, g, b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_SETUP:
          write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
        ROW_KNOWN:
          send_pixel(directed_rows[i].red, directed_rows[i].green,
                     directed_rows[i].blue, directed_rows[i].color);
        default:
          send_pixel(directed_rows[i].red, directed_rows[i].green,
                     directed_rows[i].blue,
                     predict_color(directed_rows[i].red, directed_rows[i].green,
                                   directed_rows[i].blue));
      endcase
    end

    // Random phases, one per register setting; the last setting is random
    // and may carry a set bit 6 in the gray write, which must be ignored.
    for (int phase = 0; phase <= FIXED_SETTINGS; phase++) begin
      if (phase < FIXED_SETTINGS) setting = fixed_settings[phase];
      else setting = '{7'($urandom_range(0, 127)), 7'($urandom_range(0, 127))};
      write_register(CFG_BW_THRESH, setting.bw);
      write_register(CFG_GRAY_THRESH, setting.gray);
      // Two phases hold the output off while pixels keep coming, so the
      // pipeline fills and the input side has to stall.
      if (phase == 1 || phase == 6) hold_requests++;
      for (int n = 0; n < PIXELS_PER_SET; n++) begin
        make_pixel(r, g, b);
        send_pixel(r, g, b, predict_color(r, g, b));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 5) @(posedge clk);

    $display("Covered %0d pixels under %0d register writes; %0d of 16 palette indexes seen.",
             pixels_checked, register_writes, $countones(colors_seen));
    $display("Input side stalled on %0d cycles, with %0d long output hold-offs.",
             input_stalls, hold_requests);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
